@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/gbns_pkg.sv @@
// types, codes and control store for the go-back-n sender
// no dependencies
`timescale 1ns / 1ps
package gbns_pkg;

  typedef enum logic [1:0] {
    MODE_SEND    = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_TIMEOUT = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_REFUSED = 2'd1,
    KIND_ACK     = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    TMR_NONE  = 2'd0,
    TMR_STOP  = 2'd1,
    TMR_START = 2'd2
  } tmr_e;

  typedef enum logic [2:0] {
    OP_FETCH    = 3'd0,
    OP_SEND     = 3'd1,
    OP_ACK      = 3'd2,
    OP_GB_SETUP = 3'd3,
    OP_GB_EMIT  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    BR_DISPATCH = 3'd0,
    BR_GOTO     = 3'd1,
    BR_IF_GOOD  = 3'd2,
    BR_IF_EMPTY = 3'd3,
    BR_LOOP     = 3'd4
  } br_e;

  localparam int StepW = 3;

  localparam logic [StepW-1:0] STEP_FETCH    = 3'd0;
  localparam logic [StepW-1:0] STEP_SEND     = 3'd1;
  localparam logic [StepW-1:0] STEP_ACK      = 3'd2;
  localparam logic [StepW-1:0] STEP_GB_SETUP = 3'd3;
  localparam logic [StepW-1:0] STEP_GB_EMIT  = 3'd4;

  localparam int InDataW  = 40;
  localparam int OutDataW = 48;

  typedef struct packed {
    logic             ready;
    op_e              op;
    br_e              br;
    logic [StepW-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [StepW-1:0] step);
    uword_t w;
    w = '{ready: 1'b1, op: OP_FETCH, br: BR_DISPATCH, target: STEP_FETCH};
    case (step)
      STEP_FETCH:    w = '{ready: 1'b1, op: OP_FETCH, br: BR_DISPATCH, target: STEP_FETCH};
      STEP_SEND:     w = '{ready: 1'b0, op: OP_SEND, br: BR_GOTO, target: STEP_FETCH};
      STEP_ACK:      w = '{ready: 1'b0, op: OP_ACK, br: BR_IF_GOOD, target: STEP_GB_SETUP};
      STEP_GB_SETUP: w = '{ready: 1'b0, op: OP_GB_SETUP, br: BR_IF_EMPTY,
                           target: STEP_GB_EMIT};
      STEP_GB_EMIT:  w = '{ready: 1'b0, op: OP_GB_EMIT, br: BR_LOOP, target: STEP_FETCH};
      default:       w = '{ready: 1'b1, op: OP_FETCH, br: BR_DISPATCH, target: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/go_back_n_sender.sv @@
// go-back-n sender: send, ack and timeout items in, transmit and status words out
// a send or ack item is captured at accept; its word is then registered by its send or ack step, which waits on a stall
// a new item is taken only in the fetch step, once the send, ack or resend steps of the last item are done
// retransmission rate is one frame per cycle while the output is not stalled, set by the single frame store read port
// reset clears the window counters, the sequencer and the output valid; store is not cleared
// depends on gbns_pkg and assert_macros.svh; SEQ_SPACE must be a power of two, not enforced by the block
`timescale 1ns / 1ps
`include "assert_macros.svh"
module go_back_n_sender #(
  parameter int SEQ_SPACE    = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // payload[31:0], ack_num[34:32], ack_checksum_ok[35], zero pad
  input  logic [gbns_pkg::InDataW-1:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // seq_num[2:0], frame_payload[34:3], is_retransmit[35], timer_cmd[37:36],
  // timer_seq[40:38], window_base[43:41], window_full[44], zero pad
  output logic [gbns_pkg::OutDataW-1:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]                   m_axis_tuser,
  // is_last
  output logic                         m_axis_tlast
);
  import gbns_pkg::*;

  localparam int SeqW = $clog2(SEQ_SPACE);
  localparam int Win  = SEQ_SPACE / 2;
  localparam logic [SeqW-1:0] WinV = SeqW'(Win);

  logic [PAYLOAD_BITS-1:0] mem [SEQ_SPACE];

  logic [StepW-1:0]        step_q, step_d;
  logic [SeqW-1:0]         base_q, base_d, next_q, next_d, cnt_q, cnt_d, idx_q, idx_d;
  logic [PAYLOAD_BITS-1:0] pay_q, rd_data_q;
  logic [2:0]              ack_raw_q;
  logic                    ok_q;
  logic                    out_valid_q;
  logic [OutDataW-1:0]     out_data_q, out_data_d;
  kind_e                   out_kind_q, out_kind_d;
  logic                    out_last_q, out_last_d;

  uword_t                  uw;
  logic                    accept, can_emit, adv, emit, wr_en, ack_good, gb_last;
  logic                    mode_known;
  logic [SeqW-1:0]         ack_w, ack_ofs, rel, rd_addr, cur_seq;
  kind_e                   o_kind;
  logic [SeqW-1:0]         o_seq, o_tseq;
  logic [PAYLOAD_BITS-1:0] o_pay;
  logic                    o_retx;
  tmr_e                    o_tcmd;

  assign uw       = ucode(step_q);
  assign accept   = uw.ready && s_axis_tvalid;
  assign can_emit = !out_valid_q || m_axis_tready;
  assign mode_known = (s_axis_tuser == MODE_SEND) || (s_axis_tuser == MODE_ACK) ||
                      (s_axis_tuser == MODE_TIMEOUT);

  assign ack_w    = SeqW'(ack_raw_q);
  assign ack_ofs  = ack_w - base_q;
  assign ack_good = ok_q && (cnt_q != '0) && (ack_ofs < WinV);
  assign rel      = (ack_ofs >= cnt_q) ? cnt_q : ack_ofs + 1'b1;
  assign cur_seq  = base_q + idx_q;
  assign gb_last  = (idx_q + 1'b1) == cnt_q;

  // sequencer: advance and branch
  always_comb begin
    adv    = 1'b0;
    emit   = 1'b0;
    step_d = step_q;
    case (uw.op)
      OP_FETCH: begin
        adv = s_axis_tvalid;
      end
      OP_SEND, OP_GB_EMIT: begin
        adv  = can_emit;
        emit = can_emit;
      end
      OP_ACK: begin
        adv  = ack_good ? can_emit : 1'b1;
        emit = ack_good && can_emit;
      end
      OP_GB_SETUP: begin
        adv  = (cnt_q == '0) ? can_emit : 1'b1;
        emit = (cnt_q == '0) && can_emit;
      end
      default: begin
        adv = 1'b0;
      end
    endcase
    if (adv) begin
      case (uw.br)
        BR_DISPATCH: begin
          case (s_axis_tuser)
            MODE_SEND:    step_d = STEP_SEND;
            MODE_ACK:     step_d = STEP_ACK;
            MODE_TIMEOUT: step_d = STEP_GB_SETUP;
            default:      step_d = STEP_FETCH;
          endcase
        end
        BR_GOTO:     step_d = uw.target;
        BR_IF_GOOD:  step_d = ack_good ? STEP_FETCH : uw.target;
        BR_IF_EMPTY: step_d = (cnt_q == '0) ? STEP_FETCH : uw.target;
        BR_LOOP:     step_d = gb_last ? STEP_FETCH : step_q;
        default:     step_d = STEP_FETCH;
      endcase
    end
  end

  // datapath
  always_comb begin
    base_d = base_q;
    next_d = next_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    wr_en  = 1'b0;
    o_kind = KIND_TX;
    o_seq  = '0;
    o_pay  = '0;
    o_retx = 1'b0;
    o_tcmd = TMR_NONE;
    o_tseq = '0;
    case (uw.op)
      OP_SEND: begin
        if (cnt_q >= WinV) begin
          o_kind = KIND_REFUSED;
        end else begin
          wr_en  = adv;
          o_seq  = next_q;
          o_pay  = pay_q;
          if (cnt_q == '0) begin
            o_tcmd = TMR_START;
            o_tseq = next_q;
          end
          if (adv) begin
            next_d = next_q + 1'b1;
            cnt_d  = cnt_q + 1'b1;
          end
        end
      end
      OP_ACK: begin
        o_kind = KIND_ACK;
        if (ack_good) begin
          o_seq = ack_w;
          if (cnt_q != rel) begin
            o_tcmd = TMR_START;
            o_tseq = base_q + rel;
          end else begin
            o_tcmd = TMR_STOP;
            o_tseq = base_q;
          end
          if (adv) begin
            base_d = base_q + rel;
            cnt_d  = cnt_q - rel;
          end
        end
      end
      OP_GB_SETUP: begin
        o_kind = KIND_EMPTY;
        idx_d  = '0;
      end
      OP_GB_EMIT: begin
        o_seq  = cur_seq;
        o_pay  = rd_data_q;
        o_retx = 1'b1;
        if (gb_last) begin
          o_tcmd = TMR_START;
          o_tseq = base_q;
        end
        if (adv) begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        o_kind = KIND_TX;
      end
    endcase
  end

  assign rd_addr = base_q + idx_d;

  always_comb begin
    out_data_d          = '0;
    out_data_d[2:0]     = 3'(o_seq);
    out_data_d[34:3]    = 32'(o_pay);
    out_data_d[35]      = o_retx;
    out_data_d[37:36]   = o_tcmd;
    out_data_d[40:38]   = 3'(o_tseq);
    out_data_d[43:41]   = 3'(base_d);
    out_data_d[44]      = (cnt_d == WinV);
    out_kind_d          = o_kind;
    out_last_d          = (uw.op != OP_GB_EMIT) || gb_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_FETCH;
      base_q      <= '0;
      next_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      base_q <= base_d;
      next_q <= next_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pay_q     <= PAYLOAD_BITS'(s_axis_tdata[31:0]);
      ack_raw_q <= s_axis_tdata[34:32];
      ok_q      <= s_axis_tdata[35];
    end
    if (emit) begin
      out_data_q <= out_data_d;
      out_kind_q <= out_kind_d;
      out_last_q <= out_last_d;
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[next_q] <= pay_q;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign s_axis_tready = uw.ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  `ASSERT_IMP(cnt_in_window_a, clk_i, rst_ni, 1'b1, cnt_q <= WinV, "count beyond window")
  `ASSERT_IMP(window_span_a, clk_i, rst_ni, 1'b1, next_q - base_q == cnt_q, "window span broken")
  `ASSERT_IMP(gb_index_a, clk_i, rst_ni, step_q == STEP_GB_EMIT, idx_q < cnt_q, "bad resend index")
  `ASSERT_NEXT(dispatch_a, clk_i, rst_ni, accept && mode_known, step_q != STEP_FETCH, "not dispatched")

endmodule
